// ----- rtl/core/thc_pkg.sv -----
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types, constants and helpers for the temperature/humidity
// compensation core.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int unsigned RAW_T_W   = 20;
  localparam int unsigned RAW_H_W   = 16;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned HUM_W     = 17;
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [2:0] REG_CAL_T1    = 3'd0;
  localparam logic [2:0] REG_CAL_T2    = 3'd1;
  localparam logic [2:0] REG_CAL_T3    = 3'd2;
  localparam logic [2:0] REG_CAL_H1    = 3'd3;
  localparam logic [2:0] REG_CAL_H2    = 3'd4;
  localparam logic [2:0] REG_CAL_H3    = 3'd5;
  localparam logic [2:0] REG_CAL_H4_H5 = 3'd6;
  localparam logic [2:0] REG_CAL_H6    = 3'd7;

  localparam logic [31:0] TFINE_OFFSET = 32'd76800;
  localparam logic [31:0] HUM_LIMIT    = 32'd419430400;
  localparam logic [31:0] P_ROUND      = 32'd16384;
  localparam logic [31:0] Q_OFFSET     = 32'd2097152;
  localparam logic [31:0] QB_OFFSET    = 32'd32768;
  localparam logic [31:0] QH_ROUND     = 32'd8192;
  localparam logic [31:0] T_ROUND      = 32'd128;

  typedef struct packed {
    logic [15:0] cal_t1;
    logic [15:0] cal_t2;
    logic [15:0] cal_t3;
    logic [7:0]  cal_h1;
    logic [15:0] cal_h2;
    logic [7:0]  cal_h3;
    logic [23:0] cal_h4_h5;
    logic [7:0]  cal_h6;
  } cal_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

endpackage

// ----- rtl/core/temp_humidity_compensation_core.sv -----
// ----------------------------------------------------------------------------
// temp_humidity_compensation_core
// Items pass the temperature stages, then the humidity stages, to out_tdata.
// Throughput: one item per cycle when out_tready holds; stages stall
// independently, squeezing out bubbles; items are taken while a result waits.
// Reset (rst_n, synchronous): pipeline valids cleared, calibration
// registers cleared to zero.
// ----------------------------------------------------------------------------
module temp_humidity_compensation_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [thc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [thc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [thc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [19:0] raw_temperature, [35:20] raw_humidity, [39:36] zero
  input  logic [39:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] temperature_centideg, [32:16] humidity_q10, [39:33] zero
  output logic [39:0]                 out_tdata
);
  import thc_pkg::*;

  cal_t              cal;
  logic              mid_valid, mid_ready;
  logic [31:0]       mid_tfine;
  logic [RAW_H_W-1:0] mid_raw_h;
  logic [TEMP_W-1:0] temp;
  logic [HUM_W-1:0]  hum;

  thc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cal     (cal)
  );

  thc_temp_pipe u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .raw_t    (in_tdata[19:0]),
    .raw_h    (in_tdata[35:20]),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .tfine    (mid_tfine),
    .dn_raw_h (mid_raw_h)
  );

  thc_hum_pipe u_hum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .tfine    (mid_tfine),
    .raw_h    (mid_raw_h),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .temp     (temp),
    .hum      (hum)
  );

  assign out_tdata = {7'd0, hum, temp};

endmodule

// ----- rtl/core/thc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// thc_cfg_regs
// APB-style register file holding the factory calibration words.
// ----------------------------------------------------------------------------
module thc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [thc_pkg::CFG_AW-1:0] paddr,
  input  logic [thc_pkg::CFG_DW-1:0] pwdata,
  output logic [thc_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output thc_pkg::cal_t             cal
);
  import thc_pkg::*;

  cal_t       cal_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cal    = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CAL_T1:    cal_r.cal_t1    <= pwdata[15:0];
        REG_CAL_T2:    cal_r.cal_t2    <= pwdata[15:0];
        REG_CAL_T3:    cal_r.cal_t3    <= pwdata[15:0];
        REG_CAL_H1:    cal_r.cal_h1    <= pwdata[7:0];
        REG_CAL_H2:    cal_r.cal_h2    <= pwdata[15:0];
        REG_CAL_H3:    cal_r.cal_h3    <= pwdata[7:0];
        REG_CAL_H4_H5: cal_r.cal_h4_h5 <= pwdata[23:0];
        REG_CAL_H6:    cal_r.cal_h6    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAL_T1:    prdata = {16'd0, cal_r.cal_t1};
      REG_CAL_T2:    prdata = {16'd0, cal_r.cal_t2};
      REG_CAL_T3:    prdata = {16'd0, cal_r.cal_t3};
      REG_CAL_H1:    prdata = {24'd0, cal_r.cal_h1};
      REG_CAL_H2:    prdata = {16'd0, cal_r.cal_h2};
      REG_CAL_H3:    prdata = {24'd0, cal_r.cal_h3};
      REG_CAL_H4_H5: prdata = {8'd0, cal_r.cal_h4_h5};
      REG_CAL_H6:    prdata = {24'd0, cal_r.cal_h6};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/thc_temp_pipe.sv -----
// ----------------------------------------------------------------------------
// thc_temp_pipe
// Four-stage pipeline forming the fine temperature term.
// ----------------------------------------------------------------------------
module thc_temp_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  thc_pkg::cal_t               cal,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [thc_pkg::RAW_T_W-1:0] raw_t,
  input  logic [thc_pkg::RAW_H_W-1:0] raw_h,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [31:0]                 tfine,
  output logic [thc_pkg::RAW_H_W-1:0] dn_raw_h
);
  import thc_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic [31:0] t2s, t3s;
  logic [31:0] a_nxt, b_nxt;
  logic [31:0] a_r, b_r;
  logic [31:0] pa_r, pbb_r;
  logic [31:0] var1_r, m_r;
  logic [31:0] tfine_r;
  logic [RAW_H_W-1:0] h1_r, h2_r, h3_r, h4_r;

  assign en4 = !v4_r || dn_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;

  assign t2s = {{16{cal.cal_t2[15]}}, cal.cal_t2};
  assign t3s = {{16{cal.cal_t3[15]}}, cal.cal_t3};

  always_comb begin
    a_nxt = ({12'd0, raw_t} >> 3) - {15'd0, cal.cal_t1, 1'b0};
    b_nxt = ({12'd0, raw_t} >> 4) - {16'd0, cal.cal_t1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      h1_r <= raw_h;
    end
    if (en2) begin
      pa_r  <= a_r * t2s;
      pbb_r <= b_r * b_r;
      h2_r  <= h1_r;
    end
    if (en3) begin
      var1_r <= asr32(pa_r, 5'd11);
      m_r    <= asr32(pbb_r, 5'd12) * t3s;
      h3_r   <= h2_r;
    end
    if (en4) begin
      tfine_r <= var1_r + asr32(m_r, 5'd14);
      h4_r    <= h3_r;
    end
  end

  assign dn_valid = v4_r;
  assign tfine    = tfine_r;
  assign dn_raw_h = h4_r;

endmodule

// ----- rtl/core/thc_hum_pipe.sv -----
// ----------------------------------------------------------------------------
// thc_hum_pipe
// Eight-stage pipeline for the saturated temperature and the humidity.
// ----------------------------------------------------------------------------
module thc_hum_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  thc_pkg::cal_t               cal,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [31:0]                 tfine,
  input  logic [thc_pkg::RAW_H_W-1:0] raw_h,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [thc_pkg::TEMP_W-1:0]  temp,
  output logic [thc_pkg::HUM_W-1:0]   hum
);
  import thc_pkg::*;

  localparam int unsigned NS = 8;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  logic [31:0] h1z, h2s, h3z, h4s, h5s, h6s;
  logic [31:0] x_nxt, t_nxt;
  logic [TEMP_W-1:0] tsat_nxt;
  logic [31:0] p_nxt, q2_nxt, xf_nxt;
  logic [31:0] hlim_nxt;

  logic [31:0] h5x_r, xh6_r, xh3_r;
  logic [RAW_H_W-1:0] rh_r;
  logic [31:0] p2_r, qa_r, qb_r;
  logic [31:0] p3_r, q1_r;
  logic [31:0] p4_r, q3_r;
  logic [31:0] xp5_r;
  logic [31:0] xp6_r, ss_r;
  logic [31:0] xp7_r, sh_r;
  logic [HUM_W-1:0] hum_r;
  logic [TEMP_W-1:0] tp_r [NS];

  assign en[NS-1] = !v_r[NS-1] || dn_ready;
  genvar g;
  generate
    for (g = 0; g < NS - 1; g++) begin : g_en
      assign en[g] = !v_r[g] || en[g+1];
    end
  endgenerate
  assign up_ready = en[0];

  assign h1z = {24'd0, cal.cal_h1};
  assign h2s = {{16{cal.cal_h2[15]}}, cal.cal_h2};
  assign h3z = {24'd0, cal.cal_h3};
  assign h4s = {{20{cal.cal_h4_h5[11]}}, cal.cal_h4_h5[11:0]};
  assign h5s = {{20{cal.cal_h4_h5[23]}}, cal.cal_h4_h5[23:12]};
  assign h6s = {{24{cal.cal_h6[7]}}, cal.cal_h6};

  always_comb begin
    x_nxt = tfine - TFINE_OFFSET;
    t_nxt = asr32((tfine << 2) + tfine + T_ROUND, 5'd8);
    if ($signed(t_nxt) < -32'sd32768) begin
      tsat_nxt = 16'h8000;
    end else if ($signed(t_nxt) > 32'sd32767) begin
      tsat_nxt = 16'h7fff;
    end else begin
      tsat_nxt = t_nxt[15:0];
    end
    p_nxt  = asr32(({16'd0, rh_r} << 14) - (h4s << 20) - h5x_r + P_ROUND, 5'd15);
    q2_nxt = asr32(q1_r, 5'd10) + Q_OFFSET;
    xf_nxt = xp7_r - asr32(sh_r, 5'd4);
    if (xf_nxt[31]) begin
      hlim_nxt = '0;
    end else if (xf_nxt > HUM_LIMIT) begin
      hlim_nxt = HUM_LIMIT;
    end else begin
      hlim_nxt = xf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h5x_r    <= h5s * x_nxt;
      xh6_r    <= x_nxt * h6s;
      xh3_r    <= x_nxt * h3z;
      rh_r     <= raw_h;
      tp_r[0]  <= tsat_nxt;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) tp_r[i] <= tp_r[i-1];
    end
    if (en[1]) begin
      p2_r <= p_nxt;
      qa_r <= asr32(xh6_r, 5'd10);
      qb_r <= asr32(xh3_r, 5'd11) + QB_OFFSET;
    end
    if (en[2]) begin
      p3_r <= p2_r;
      q1_r <= qa_r * qb_r;
    end
    if (en[3]) begin
      p4_r <= p3_r;
      q3_r <= q2_nxt * h2s;
    end
    if (en[4]) begin
      xp5_r <= p4_r * asr32(q3_r + QH_ROUND, 5'd14);
    end
    if (en[5]) begin
      xp6_r <= xp5_r;
      ss_r  <= asr32(xp5_r, 5'd15) * asr32(xp5_r, 5'd15);
    end
    if (en[6]) begin
      xp7_r <= xp6_r;
      sh_r  <= asr32(ss_r, 5'd7) * h1z;
    end
    if (en[7]) begin
      hum_r <= hlim_nxt[28:12];
    end
  end

  assign dn_valid = v_r[NS-1];
  assign temp     = tp_r[NS-1];
  assign hum      = hum_r;

endmodule

// ----- sim/thc_compensation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_compensation_checker
// Watches the calibration port and both streams of the compensation core.
// It keeps its own copy of the calibration words and computes the
// compensated reading for every item taken in. Each result leaving the core
// is checked against the oldest reading still outstanding.
// ----------------------------------------------------------------------------
module thc_compensation_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [thc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [thc_pkg::CFG_DW-1:0]  cfg_pwdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // [19:0] raw_temperature, [35:20] raw_humidity, [39:36] zero
  input  logic [39:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] temperature_centideg, [32:16] humidity_q10, [39:33] zero
  input  logic [39:0]                 out_tdata,
  output int                          errors,
  output int                          outstanding
);
  import thc_pkg::*;

  typedef struct packed {
    logic [15:0] temp;
    logic [16:0] hum;
  } reading_t;

  cal_t     cal_words;
  reading_t pending_readings[$];

  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic reading_t compensate_sample(input logic [19:0] raw_t,
                                                 input logic [15:0] raw_h,
                                                 input cal_t c);
    logic [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, v1, v2, tfine, t, x, p, q, s;
    reading_t r;
    at = {12'd0, raw_t};
    ah = {16'd0, raw_h};
    t1 = {16'd0, c.cal_t1};
    t2 = {{16{c.cal_t2[15]}}, c.cal_t2};
    t3 = {{16{c.cal_t3[15]}}, c.cal_t3};
    h1 = {24'd0, c.cal_h1};
    h2 = {{16{c.cal_h2[15]}}, c.cal_h2};
    h3 = {24'd0, c.cal_h3};
    h4 = {{20{c.cal_h4_h5[11]}}, c.cal_h4_h5[11:0]};
    h5 = {{20{c.cal_h4_h5[23]}}, c.cal_h4_h5[23:12]};
    h6 = {{24{c.cal_h6[7]}}, c.cal_h6};

    a     = (at >> 3) - (t1 << 1);
    v1    = shr_arith(a * t2, 11);
    b     = (at >> 4) - t1;
    v2    = shr_arith(shr_arith(b * b, 12) * t3, 14);
    tfine = v1 + v2;
    t     = shr_arith(tfine * 32'd5 + T_ROUND, 8);
    if (t[31]) begin
      r.temp = (t < 32'hFFFF_8000) ? 16'h8000 : t[15:0];
    end else begin
      r.temp = (t > 32'd32767) ? 16'h7FFF : t[15:0];
    end

    x = tfine - TFINE_OFFSET;
    p = (ah << 14) - (h4 << 20) - (h5 * x) + P_ROUND;
    p = shr_arith(p, 15);
    q = shr_arith(x * h6, 10) * (shr_arith(x * h3, 11) + QB_OFFSET);
    q = shr_arith(q, 10) + Q_OFFSET;
    q = shr_arith(q * h2 + QH_ROUND, 14);
    x = p * q;
    s = shr_arith(x, 15);
    x = x - shr_arith(shr_arith(s * s, 7) * h1, 4);
    if (x[31]) begin
      x = 32'd0;
    end else if (x > HUM_LIMIT) begin
      x = HUM_LIMIT;
    end
    r.hum = x[28:12];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t got, want;
    if (!rst_n) begin
      cal_words = '0;
      pending_readings.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.temp = out_tdata[15:0];
        got.hum  = out_tdata[32:16];
        if (pending_readings.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: temperature %0d humidity %0d",
                     $signed(got.temp), got.hum);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          if (got.temp !== want.temp || got.hum !== want.hum) begin
            if (errors < 10)
              $display("mismatch: temperature exp %0d got %0d, humidity exp %0d got %0d",
                       $signed(want.temp), $signed(got.temp), want.hum, got.hum);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_readings.push_back(compensate_sample(in_tdata[19:0], in_tdata[35:20],
                                                     cal_words));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_CAL_T1:    cal_words.cal_t1    = cfg_pwdata[15:0];
          REG_CAL_T2:    cal_words.cal_t2    = cfg_pwdata[15:0];
          REG_CAL_T3:    cal_words.cal_t3    = cfg_pwdata[15:0];
          REG_CAL_H1:    cal_words.cal_h1    = cfg_pwdata[7:0];
          REG_CAL_H2:    cal_words.cal_h2    = cfg_pwdata[15:0];
          REG_CAL_H3:    cal_words.cal_h3    = cfg_pwdata[7:0];
          REG_CAL_H4_H5: cal_words.cal_h4_h5 = cfg_pwdata[23:0];
          REG_CAL_H6:    cal_words.cal_h6    = cfg_pwdata[7:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_readings.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the temperature/humidity compensation core. Loads a series
// of calibration sets, from reset defaults through extremes to realistic
// and fully random words, and streams raw sample pairs through the core
// with bursty input and a stalling receiver. Checking is left to the
// compensation checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import thc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 175;

  logic                clk;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;
  logic                in_tvalid;
  logic                in_tready;
  logic [39:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;

  int errors;
  int outstanding;
  int cycles = 0;
  int burst_left;
  int stall_run = 0;
  bit tx_free;
  bit rx_free;

  temp_humidity_compensation_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  thc_compensation_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall runs unless running free
  always @(negedge clk) begin
    if (rx_free) begin
      out_tready <= 1'b1;
    end else if (stall_run > 0) begin
      out_tready <= 1'b0;
      stall_run  <= stall_run - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_run  <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // junk fills the bits above each register's width
  task automatic load_cal(input cal_t c, input bit junk);
    logic [31:0] j;
    j = junk ? $urandom() : 32'd0;
    cfg_write(REG_CAL_T1,    {j[31:16], c.cal_t1});
    cfg_write(REG_CAL_T2,    {j[31:16], c.cal_t2});
    cfg_write(REG_CAL_T3,    {j[31:16], c.cal_t3});
    cfg_write(REG_CAL_H1,    {j[31:8],  c.cal_h1});
    cfg_write(REG_CAL_H2,    {j[31:16], c.cal_h2});
    cfg_write(REG_CAL_H3,    {j[31:8],  c.cal_h3});
    cfg_write(REG_CAL_H4_H5, {j[31:24], c.cal_h4_h5});
    cfg_write(REG_CAL_H6,    {j[31:8],  c.cal_h6});
  endtask

  function automatic cal_t typical_cal();
    cal_t c;
    c.cal_t1    = 16'($urandom_range(26000, 29000));
    c.cal_t2    = 16'($urandom_range(25000, 27500));
    c.cal_t3    = 16'(int'($urandom_range(0, 1250)) - 1200);
    c.cal_h1    = 8'($urandom_range(0, 100));
    c.cal_h2    = 16'($urandom_range(300, 420));
    c.cal_h3    = 8'($urandom_range(0, 10));
    c.cal_h4_h5 = {12'($urandom_range(0, 60)), 12'($urandom_range(250, 400))};
    c.cal_h6    = 8'($urandom_range(0, 40));
    return c;
  endfunction

  function automatic cal_t random_cal();
    cal_t c;
    c.cal_t1    = 16'($urandom());
    c.cal_t2    = 16'($urandom());
    c.cal_t3    = 16'($urandom());
    c.cal_h1    = 8'($urandom());
    c.cal_h2    = 16'($urandom());
    c.cal_h3    = 8'($urandom());
    c.cal_h4_h5 = 24'($urandom());
    c.cal_h6    = 8'($urandom());
    return c;
  endfunction

  // entered and left at a falling edge
  task automatic send_sample(input logic [19:0] raw_t, input logic [15:0] raw_h);
    int gap;
    if (burst_left == 0) begin
      gap = tx_free ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, raw_h, raw_t};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    cal_t c;
    bit   typical;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_free     = 1'b0;
    rx_free     = 1'b0;
    burst_left  = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset calibration
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    drain();

    c.cal_t1 = 16'd27504; c.cal_t2 = 16'd26435; c.cal_t3 = -16'sd1000;
    c.cal_h1 = 8'd75;     c.cal_h2 = 16'd362;   c.cal_h3 = 8'd0;
    c.cal_h4_h5 = {12'd50, 12'd313};            c.cal_h6 = 8'd30;
    load_cal(c, 1'b0);
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd519888, 16'd30000);
    send_sample(20'd519888, 16'd0);
    send_sample(20'd519888, 16'hFFFF);
    send_sample(20'd0, 16'hFFFF);
    send_sample(20'hFFFFF, 16'd0);
    send_sample(20'd400000, 16'd25000);
    drain();

    // largest coefficients: temperature saturates, products wrap
    c.cal_t1 = 16'hFFFF; c.cal_t2 = 16'h7FFF; c.cal_t3 = 16'h7FFF;
    c.cal_h1 = 8'hFF;    c.cal_h2 = 16'h7FFF; c.cal_h3 = 8'hFF;
    c.cal_h4_h5 = {12'h7FF, 12'h7FF};         c.cal_h6 = 8'h7F;
    load_cal(c, 1'b1);
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd80000, 16'd8000);
    send_sample(20'hFFFFF, 16'd0);
    drain();

    c.cal_t1 = 16'h0000; c.cal_t2 = 16'h8000; c.cal_t3 = 16'h8000;
    c.cal_h1 = 8'h00;    c.cal_h2 = 16'h8000; c.cal_h3 = 8'h00;
    c.cal_h4_h5 = {12'h800, 12'h800};         c.cal_h6 = 8'h80;
    load_cal(c, 1'b1);
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd80000, 16'd8000);
    send_sample(20'd0, 16'hFFFF);
    drain();

    load_cal('1, 1'b0);
    send_sample(20'd0, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'h55555, 16'hAAAA);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      typical = ph[0];
      c = typical ? typical_cal() : random_cal();
      load_cal(c, 1'($urandom_range(0, 1)));
      tx_free = (ph == 0 || ph == 5);
      rx_free <= (ph == 0 || ph == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (typical && $urandom_range(0, 3) != 0)
          send_sample(20'($urandom_range(400000, 600000)),
                      16'($urandom_range(20000, 45000)));
        else
          send_sample(20'($urandom()), 16'($urandom()));
        // hold off once mid-phase until the pipeline is empty
        if (ph == 3 && n == 80) begin
          in_tvalid <= 1'b0;
          while (outstanding != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (errors == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
